/* design/smt_pkg.sv */
// ----------------------------------------------------------------------------
// smt_pkg: shared types and constants for the subscription match table
// Opcodes, status codes, command kinds, queue entry and result layouts.
// ----------------------------------------------------------------------------
package smt_pkg;

  localparam int SLOT_COUNT_DEF = 16;
  localparam int QUEUE_DEPTH    = 2;
  localparam int TOKEN_W        = 32;

  typedef enum logic [1:0] {
    OP_SUBSCRIBE   = 2'd0,
    OP_UNSUBSCRIBE = 2'd1,
    OP_PUBLISH     = 2'd2,
    OP_RESERVED    = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_INVALID   = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  // Command kind as decided by the front end
  typedef enum logic [1:0] {
    K_SUB    = 2'd0,
    K_UNSUB  = 2'd1,
    K_PUB    = 2'd2,
    K_REJECT = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    BK_IDLE  = 2'd0,
    BK_SCAN  = 2'd1,
    BK_FLUSH = 2'd2
  } back_state_t;

  typedef struct packed {
    kind_t              kind;
    logic [TOKEN_W-1:0] topic;
    logic [TOKEN_W-1:0] hnd;
    logic [TOKEN_W-1:0] ctx;
    logic [TOKEN_W-1:0] evt;
  } cmd_t;

  typedef struct packed {
    logic [TOKEN_W-1:0] topic;
    logic [TOKEN_W-1:0] hnd;
    logic [TOKEN_W-1:0] ctx;
  } slot_t;

  typedef struct packed {
    status_t            status;
    logic               deliver;
    logic [TOKEN_W-1:0] hnd;
    logic [TOKEN_W-1:0] ctx;
    logic [TOKEN_W-1:0] evt;
    logic               last;
  } result_t;

  // Handshake between front end and command queue
  typedef struct packed {
    logic push;
    logic full;
  } q_ctrl_t;

endpackage

/* design/smt_front.sv */
// ----------------------------------------------------------------------------
// smt_front: command intake and classification
// Accepts items, rejects the unused opcode and null tokens on subscribe and unsubscribe, pushes commands.
// ----------------------------------------------------------------------------
module smt_front (
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    in_opcode,
  input  logic [smt_pkg::TOKEN_W-1:0]   in_topic,
  input  logic [smt_pkg::TOKEN_W-1:0]   in_handler_id,
  input  logic [smt_pkg::TOKEN_W-1:0]   in_context_id,
  input  logic [smt_pkg::TOKEN_W-1:0]   in_event_id,
  input  logic                          q_full,
  output smt_pkg::q_ctrl_t              q_ctrl,
  output smt_pkg::cmd_t                 q_cmd
);

  logic null_tok;

  // Stall intake only while the queue has no room
  assign busy        = q_full;
  assign q_ctrl.full = q_full;
  assign q_ctrl.push = start & ~q_full;

  assign null_tok = (in_handler_id == '0) || (in_context_id == '0);

  // Classify the item
  always_comb begin
    q_cmd.topic = in_topic;
    q_cmd.hnd   = in_handler_id;
    q_cmd.ctx   = in_context_id;
    q_cmd.evt   = in_event_id;
    unique case (smt_pkg::opcode_t'(in_opcode))
      smt_pkg::OP_SUBSCRIBE: begin
        q_cmd.kind = null_tok ? smt_pkg::K_REJECT : smt_pkg::K_SUB;
      end
      smt_pkg::OP_UNSUBSCRIBE: begin
        q_cmd.kind = null_tok ? smt_pkg::K_REJECT : smt_pkg::K_UNSUB;
      end
      smt_pkg::OP_PUBLISH: begin
        q_cmd.kind = smt_pkg::K_PUB;
      end
      default: begin
        q_cmd.kind = smt_pkg::K_REJECT;
      end
    endcase
  end

endmodule

/* design/smt_queue.sv */
// ----------------------------------------------------------------------------
// smt_queue: short command queue between front end and back end
// Lets intake keep taking items while the back end sweeps the table.
// ----------------------------------------------------------------------------
module smt_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  smt_pkg::q_ctrl_t q_ctrl,
  input  smt_pkg::cmd_t    push_cmd,
  input  logic             pop,
  output smt_pkg::cmd_t    pop_cmd,
  output logic             full,
  output logic             empty
);

  localparam int PW = (smt_pkg::QUEUE_DEPTH > 1) ? $clog2(smt_pkg::QUEUE_DEPTH) : 1;
  localparam int NW = $clog2(smt_pkg::QUEUE_DEPTH + 1);

  smt_pkg::cmd_t  entry_r [smt_pkg::QUEUE_DEPTH];
  logic [PW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [NW-1:0]  cnt_r, cnt_nxt;
  logic           do_push, do_pop;

  assign full    = (cnt_r == NW'(smt_pkg::QUEUE_DEPTH));
  assign empty   = (cnt_r == '0);
  assign pop_cmd = entry_r[rd_ptr_r];
  assign do_push = q_ctrl.push & ~q_ctrl.full;
  assign do_pop  = pop & ~empty;

  // Advance pointers and count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(smt_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(smt_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Hold entries
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

/* design/smt_back.sv */
// ----------------------------------------------------------------------------
// smt_back: table sweep sequencer
// Holds the slot store and active bits, executes one command at a time by
// walking the slots in order, and drives the registered result.
// ----------------------------------------------------------------------------
module smt_back #(
  parameter int SLOT_COUNT = smt_pkg::SLOT_COUNT_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_empty,
  input  smt_pkg::cmd_t    q_cmd,
  output logic             pop,
  output logic             res_valid,
  output smt_pkg::result_t res
);

  localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CW = $clog2(SLOT_COUNT + 1);
  localparam logic [IW-1:0] LAST_IDX = IW'(SLOT_COUNT - 1);

  smt_pkg::back_state_t        state_r, state_nxt;
  smt_pkg::cmd_t               cur_r, cur_nxt;
  logic [CW-1:0]               idx_r, idx_nxt;
  logic                        found_r, found_nxt;
  logic                        pend_r, pend_nxt;
  logic [smt_pkg::TOKEN_W-1:0] pend_hnd_r, pend_hnd_nxt;
  logic [smt_pkg::TOKEN_W-1:0] pend_ctx_r, pend_ctx_nxt;
  logic [SLOT_COUNT-1:0]       act_r, act_nxt;
  logic                        res_valid_r, res_valid_nxt;
  smt_pkg::result_t            res_r, res_nxt;

  // Slot store and its read stage
  smt_pkg::slot_t              slot_mem [SLOT_COUNT];
  smt_pkg::slot_t              rdata_r;
  logic                        rvalid_r;
  logic [IW-1:0]               ridx_r;
  logic                        ract_r;
  logic [IW-1:0]               raddr;
  logic                        issue;
  logic                        mem_we;
  logic [IW-1:0]               widx;
  smt_pkg::slot_t              wdata;
  logic                        hit_unsub, hit_pub;

  assign raddr = idx_r[IW-1:0];
  assign issue = (state_r == smt_pkg::BK_SCAN) && (cur_r.kind != smt_pkg::K_SUB) &&
                 (idx_r < CW'(SLOT_COUNT));
  assign widx  = idx_r[IW-1:0];
  assign wdata = '{topic: cur_r.topic, hnd: cur_r.hnd, ctx: cur_r.ctx};

  assign hit_unsub = ract_r && (rdata_r.hnd == cur_r.hnd) && (rdata_r.ctx == cur_r.ctx);
  assign hit_pub   = ract_r && (rdata_r.topic == cur_r.topic);

  assign res_valid = res_valid_r;
  assign res       = res_r;

  // Sequence commands over the slots
  always_comb begin
    state_nxt     = state_r;
    cur_nxt       = cur_r;
    idx_nxt       = idx_r;
    found_nxt     = found_r;
    pend_nxt      = pend_r;
    pend_hnd_nxt  = pend_hnd_r;
    pend_ctx_nxt  = pend_ctx_r;
    act_nxt       = act_r;
    pop           = 1'b0;
    mem_we        = 1'b0;
    res_valid_nxt = 1'b0;
    res_nxt       = '{status: smt_pkg::ST_OK, deliver: 1'b0, hnd: '0, ctx: '0,
                      evt: '0, last: 1'b1};
    unique case (state_r)
      smt_pkg::BK_IDLE: begin
        if (!q_empty) begin
          pop       = 1'b1;
          cur_nxt   = q_cmd;
          idx_nxt   = '0;
          found_nxt = 1'b0;
          pend_nxt  = 1'b0;
          if (q_cmd.kind == smt_pkg::K_REJECT) begin
            res_valid_nxt  = 1'b1;
            res_nxt.status = smt_pkg::ST_INVALID;
          end else begin
            state_nxt = smt_pkg::BK_SCAN;
          end
        end
      end
      smt_pkg::BK_SCAN: begin
        if (cur_r.kind == smt_pkg::K_SUB) begin
          // Take the lowest free slot, one slot a cycle
          if (!act_r[widx]) begin
            mem_we        = 1'b1;
            act_nxt[widx] = 1'b1;
            res_valid_nxt = 1'b1;
            state_nxt     = smt_pkg::BK_IDLE;
          end else if (widx == LAST_IDX) begin
            res_valid_nxt  = 1'b1;
            res_nxt.status = smt_pkg::ST_FULL;
            state_nxt      = smt_pkg::BK_IDLE;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end else begin
          if (issue) begin
            idx_nxt = idx_r + 1'b1;
          end
          if (rvalid_r) begin
            if (cur_r.kind == smt_pkg::K_UNSUB) begin
              // Drop every matching subscription
              if (hit_unsub) begin
                act_nxt[ridx_r] = 1'b0;
                found_nxt       = 1'b1;
              end
            end else if (hit_pub) begin
              // Release the previous match, hold this one until a later one shows
              if (pend_r) begin
                res_valid_nxt   = 1'b1;
                res_nxt.deliver = 1'b1;
                res_nxt.hnd     = pend_hnd_r;
                res_nxt.ctx     = pend_ctx_r;
                res_nxt.evt     = cur_r.evt;
                res_nxt.last    = 1'b0;
              end
              pend_nxt     = 1'b1;
              pend_hnd_nxt = rdata_r.hnd;
              pend_ctx_nxt = rdata_r.ctx;
            end
            if (ridx_r == LAST_IDX) begin
              state_nxt = smt_pkg::BK_FLUSH;
            end
          end
        end
      end
      smt_pkg::BK_FLUSH: begin
        // Emit the closing result
        res_valid_nxt = 1'b1;
        state_nxt     = smt_pkg::BK_IDLE;
        pend_nxt      = 1'b0;
        if (cur_r.kind == smt_pkg::K_UNSUB) begin
          res_nxt.status = found_r ? smt_pkg::ST_OK : smt_pkg::ST_NOT_FOUND;
        end else if (pend_r) begin
          res_nxt.deliver = 1'b1;
          res_nxt.hnd     = pend_hnd_r;
          res_nxt.ctx     = pend_ctx_r;
          res_nxt.evt     = cur_r.evt;
        end
      end
      default: begin
        state_nxt = smt_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= smt_pkg::BK_IDLE;
      idx_r       <= '0;
      found_r     <= 1'b0;
      pend_r      <= 1'b0;
      act_r       <= '0;
      res_valid_r <= 1'b0;
      rvalid_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      found_r     <= found_nxt;
      pend_r      <= pend_nxt;
      act_r       <= act_nxt;
      res_valid_r <= res_valid_nxt;
      rvalid_r    <= issue;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    pend_hnd_r <= pend_hnd_nxt;
    pend_ctx_r <= pend_ctx_nxt;
    res_r      <= res_nxt;
    ridx_r     <= raddr;
    ract_r     <= act_r[raddr];
  end

  // Slot store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      slot_mem[widx] <= wdata;
    end
    rdata_r <= slot_mem[raddr];
  end

  // The closing cycle of a sweep always produces a result
  a_flush_emits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == smt_pkg::BK_FLUSH) |=> res_valid_r)
    else $error("flush cycle produced no result");

  // A subscription never overwrites a live slot
  a_write_free: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (!act_r[widx] && (cur_r.kind == smt_pkg::K_SUB)))
    else $error("slot store written over an active slot");

  // A held match exists only during a publish sweep
  a_pend_pub: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> ((cur_r.kind == smt_pkg::K_PUB) && (state_r != smt_pkg::BK_IDLE)))
    else $error("held match outside a publish sweep");

  // Read data arrives only while the sweep is running
  a_read_scan: assert property (@(posedge clk) disable iff (!rst_n)
    rvalid_r |-> (state_r == smt_pkg::BK_SCAN))
    else $error("slot read returned outside a sweep");

endmodule

/* design/subscription_match_table_top.sv */
// ----------------------------------------------------------------------------
// subscription_match_table_top: publish/subscribe slot table
// Front end classifies items into a short queue; back end sweeps the slots.
// ----------------------------------------------------------------------------
//   channel   handshake            payload
//   input     start / busy         in_opcode, in_topic, in_handler_id,
//                                  in_context_id, in_event_id
//   result    out_valid (strobe)   out_status, out_deliver, out_handler,
//                                  out_context, out_event, out_last
//
// A rejected item is answered from the idle state; subscribe probes one slot a
// cycle for the lowest free slot; unsubscribe and publish walk every slot over
// the single read port of the slot store, then its registered read and a
// closing cycle. Publish emits at most one result a cycle.
// Reset (rst_n low, synchronous) clears all active bits, the queue and the
// sequencer. busy rises only when the two-entry command queue is full.
// Results are strobed for one cycle and cannot be held off by the receiver.
// ----------------------------------------------------------------------------
module subscription_match_table_top #(
  parameter int SLOT_COUNT = smt_pkg::SLOT_COUNT_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  in_opcode,
  input  logic [smt_pkg::TOKEN_W-1:0] in_topic,
  input  logic [smt_pkg::TOKEN_W-1:0] in_handler_id,
  input  logic [smt_pkg::TOKEN_W-1:0] in_context_id,
  input  logic [smt_pkg::TOKEN_W-1:0] in_event_id,
  output logic                        out_valid,
  output logic [1:0]                  out_status,
  output logic                        out_deliver,
  output logic [smt_pkg::TOKEN_W-1:0] out_handler,
  output logic [smt_pkg::TOKEN_W-1:0] out_context,
  output logic [smt_pkg::TOKEN_W-1:0] out_event,
  output logic                        out_last
);

  smt_pkg::q_ctrl_t q_ctrl;
  smt_pkg::cmd_t    push_cmd;
  smt_pkg::cmd_t    pop_cmd;
  logic             q_full;
  logic             q_empty;
  logic             pop;
  smt_pkg::result_t res;

  smt_front u_front (
    .start         (start),
    .busy          (busy),
    .in_opcode     (in_opcode),
    .in_topic      (in_topic),
    .in_handler_id (in_handler_id),
    .in_context_id (in_context_id),
    .in_event_id   (in_event_id),
    .q_full        (q_full),
    .q_ctrl        (q_ctrl),
    .q_cmd         (push_cmd)
  );

  smt_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_ctrl   (q_ctrl),
    .push_cmd (push_cmd),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .full     (q_full),
    .empty    (q_empty)
  );

  smt_back #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_cmd     (pop_cmd),
    .pop       (pop),
    .res_valid (out_valid),
    .res       (res)
  );

  // Unpack the result register onto the ports
  assign out_status  = res.status;
  assign out_deliver = res.deliver;
  assign out_handler = res.hnd;
  assign out_context = res.ctx;
  assign out_event   = res.evt;
  assign out_last    = res.last;

endmodule
